// File: sv/mma_pkg.sv
// mma_pkg: shared byte type, status code constants and message length tables
// for the midi message assembler; no dependencies
`timescale 1ns / 1ps

package mma_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] msg_len_t;

  // status byte classes and special codes
  localparam byte_t RT_FIRST     = 8'hF8;
  localparam byte_t ACTIVE_SENSE = 8'hFE;
  localparam byte_t SYS_FIRST    = 8'hF0;
  localparam byte_t SX_START     = 8'hF0;
  localparam byte_t SX_END       = 8'hF7;
  localparam byte_t STATUS_FIRST = 8'h80;

  // full length of a channel voice message, indexed by status bits 6:4
  function automatic msg_len_t chan_msg_len(input logic [2:0] sel);
    msg_len_t len;
    case (sel)
      3'd4, 3'd5: len = 2'd2;
      default:    len = 2'd3;
    endcase
    return len;
  endfunction

  // full length of a system common message, indexed by status bits 2:0
  function automatic msg_len_t sys_msg_len(input logic [2:0] sel);
    msg_len_t len;
    case (sel)
      3'd1, 3'd3: len = 2'd2;
      3'd2:       len = 2'd3;
      3'd6, 3'd7: len = 2'd1;
      default:    len = 2'd0;
    endcase
    return len;
  endfunction

endpackage

// File: sv/mma_cmd_fifo.sv
// mma_cmd_fifo: two-entry command queue between the parser front and the
// emitter back; no dependencies
`timescale 1ns / 1ps

module mma_cmd_fifo #(
  parameter int W = 14
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  logic [W-1:0] slot_r [2];
  logic         wr_r;
  logic         rd_r;
  logic [1:0]   cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = slot_r[rd_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= din;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: sv/mma_front.sv
// mma_front: accepts raw midi bytes, tracks running status and fill count,
// writes message bytes and queues emit commands; depends on mma_pkg
`timescale 1ns / 1ps

module mma_front
  import mma_pkg::*;
#(
  parameter int MSG_MAX = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  byte_t                               in_byte,
  output logic                                cmd_push,
  output logic [1+8+$clog2(MSG_MAX+1)-1:0]    cmd_data,
  input  logic                                cmd_full,
  output logic                                mem_we,
  output logic [$clog2(MSG_MAX):0]            mem_waddr,
  output byte_t                               mem_wdata,
  input  logic                                rel_v,
  input  logic                                rel_bank
);

  localparam int FILL_W = $clog2(MSG_MAX + 1);
  localparam int IDX_W  = $clog2(MSG_MAX);

  typedef struct packed {
    logic              bank;
    byte_t             head;
    logic [FILL_W-1:0] count;
  } cmd_t;

  localparam logic [FILL_W-1:0] ONE    = FILL_W'(1);
  localparam logic [FILL_W-1:0] TWO    = FILL_W'(2);
  localparam logic [FILL_W-1:0] FULL_N = FILL_W'(MSG_MAX);

  byte_t             rs_r, rs_nxt;
  msg_len_t          exp_r, exp_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  byte_t             head_r, head_nxt;
  logic              bank_r, bank_nxt;
  logic [1:0]        busy_r, busy_nxt;

  logic              accept;
  logic              push;
  cmd_t              cmd;
  logic              we;
  logic [FILL_W-1:0] wpos;
  logic [FILL_W-1:0] put_fill;
  logic [FILL_W-1:0] inc_fill;

  // stall while the queue is full or the write bank is still being emitted
  assign in_ready = !cmd_full && !busy_r[bank_r];
  assign accept   = in_valid && in_ready;
  assign inc_fill = fill_r + ONE;

  // classify the beat and update parser state
  always_comb begin
    rs_nxt    = rs_r;
    exp_nxt   = exp_r;
    fill_nxt  = fill_r;
    head_nxt  = head_r;
    bank_nxt  = bank_r;
    busy_nxt  = busy_r;
    push      = 1'b0;
    cmd.bank  = bank_r;
    cmd.head  = head_r;
    cmd.count = ONE;
    we        = 1'b0;
    wpos      = fill_r;
    put_fill  = inc_fill;

    if (rel_v) begin
      busy_nxt[rel_bank] = 1'b0;
    end

    if (accept) begin
      if (in_byte >= RT_FIRST) begin
        // real-time: pass through, active sensing dropped
        if (in_byte != ACTIVE_SENSE) begin
          push     = 1'b1;
          cmd.head = in_byte;
        end
      end else if (in_byte == SX_END) begin
        // sysex end: flush held bytes plus the end byte
        if (rs_r == SX_START) begin
          if (fill_r == '0) begin
            head_nxt = in_byte;
          end else begin
            we = 1'b1;
          end
          push      = 1'b1;
          cmd.head  = head_nxt;
          cmd.count = inc_fill;
        end
        rs_nxt   = '0;
        fill_nxt = '0;
      end else if (in_byte >= STATUS_FIRST) begin
        // new status starts a message
        if (in_byte >= SYS_FIRST) begin
          exp_nxt = sys_msg_len(in_byte[2:0]);
        end else begin
          exp_nxt = chan_msg_len(in_byte[6:4]);
        end
        head_nxt = in_byte;
        rs_nxt   = in_byte;
        fill_nxt = ONE;
        if (exp_nxt == 2'd1) begin
          push     = 1'b1;
          cmd.head = in_byte;
          rs_nxt   = '0;
          fill_nxt = '0;
        end
      end else if (rs_r != '0) begin
        // data byte, running status re-inserted at message start
        if (fill_r == '0 && rs_r != SX_START) begin
          head_nxt = rs_r;
          we       = 1'b1;
          wpos     = ONE;
          put_fill = TWO;
        end else if (fill_r == '0) begin
          head_nxt = in_byte;
          put_fill = ONE;
        end else begin
          we = 1'b1;
        end
        cmd.head  = head_nxt;
        cmd.count = put_fill;
        if (put_fill == {{(FILL_W-2){1'b0}}, exp_r}) begin
          push = 1'b1;
          if (rs_r >= SYS_FIRST) begin
            rs_nxt = '0;
          end
          fill_nxt = '0;
        end else if (put_fill >= FULL_N) begin
          push     = 1'b1;
          fill_nxt = '0;
        end else begin
          fill_nxt = put_fill;
        end
      end

      // a command that reads the store hands its bank to the back
      if (push && cmd.count > ONE) begin
        busy_nxt[bank_r] = 1'b1;
        bank_nxt         = ~bank_r;
      end
    end
  end

  assign cmd_push  = push;
  assign cmd_data  = cmd;
  assign mem_we    = we;
  assign mem_waddr = {bank_r, wpos[IDX_W-1:0]};
  assign mem_wdata = in_byte;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r   <= '0;
      exp_r  <= '0;
      fill_r <= '0;
      bank_r <= 1'b0;
      busy_r <= '0;
    end else begin
      rs_r   <= rs_nxt;
      exp_r  <= exp_nxt;
      fill_r <= fill_nxt;
      bank_r <= bank_nxt;
      busy_r <= busy_nxt;
    end
  end

  // first byte of the message being built
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
  end

endmodule

// File: sv/mma_back.sv
// mma_back: holds the two-bank message store and emits queued messages
// beat by beat through an output register; depends on mma_pkg
`timescale 1ns / 1ps

module mma_back
  import mma_pkg::*;
#(
  parameter int MSG_MAX = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cmd_empty,
  output logic                                cmd_pop,
  input  logic [1+8+$clog2(MSG_MAX+1)-1:0]    cmd_data,
  input  logic                                mem_we,
  input  logic [$clog2(MSG_MAX):0]            mem_waddr,
  input  byte_t                               mem_wdata,
  output logic                                rel_v,
  output logic                                rel_bank,
  output logic                                out_valid,
  input  logic                                out_ready,
  output byte_t                               out_byte,
  output logic                                out_last
);

  localparam int FILL_W = $clog2(MSG_MAX + 1);
  localparam int IDX_W  = $clog2(MSG_MAX);
  localparam int DEPTH  = 2 ** (IDX_W + 1);

  typedef struct packed {
    logic              bank;
    byte_t             head;
    logic [FILL_W-1:0] count;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SEND
  } state_t;

  state_t            state_r;
  cmd_t              cur_r;
  logic [FILL_W-1:0] k_r;
  logic [FILL_W-1:0] k_inc;
  logic              is_last;
  byte_t             store_r [DEPTH];
  byte_t             rdata_r;
  logic [IDX_W:0]    raddr;
  logic              out_valid_r;
  byte_t             out_byte_r;
  logic              out_last_r;
  logic              rel_v_r;
  logic              rel_bank_r;

  assign cmd_pop = (state_r == ST_IDLE) && !cmd_empty;
  assign k_inc   = k_r + FILL_W'(1);
  assign is_last = (k_inc == cur_r.count);
  assign raddr   = {cur_r.bank, k_r[IDX_W-1:0]};

  // message store: front writes, back reads with registered data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[mem_waddr] <= mem_wdata;
    end
    rdata_r <= store_r[raddr];
  end

  // emitter: one beat per fetch and send
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      rel_v_r     <= 1'b0;
      rel_bank_r  <= 1'b0;
    end else begin
      rel_v_r <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!cmd_empty) begin
            cur_r   <= cmd_data;
            k_r     <= '0;
            state_r <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state_r <= ST_SEND;
        end
        ST_SEND: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_byte_r  <= (k_r == '0) ? cur_r.head : rdata_r;
            out_last_r  <= is_last;
            if (is_last) begin
              state_r <= ST_IDLE;
              if (cur_r.count > FILL_W'(1)) begin
                rel_v_r    <= 1'b1;
                rel_bank_r <= cur_r.bank;
              end
            end else begin
              k_r     <= k_inc;
              state_r <= ST_FETCH;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign rel_v     = rel_v_r;
  assign rel_bank  = rel_bank_r;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

// File: sv/midi_message_assembler.sv
// midi_message_assembler: raw midi bytes in, assembled messages out beat by beat.
// input: one byte per cycle while the command queue has room and the store bank
// being filled is free. output: the emitter takes each queued command, then for
// each beat reads the store (fetch state) and loads the output register (send state),
// which waits on out_ready. reset: synchronous active-low rst_n clears running status,
// fill count, queue and emitter; the message store holds no reset value.
`timescale 1ns / 1ps

module midi_message_assembler
  import mma_pkg::*;
#(
  parameter int MSG_MAX = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  byte_t in_byte,
  output logic  out_valid,
  input  logic  out_ready,
  output byte_t out_byte,
  output logic  out_last_of_message
);

  localparam int FILL_W = $clog2(MSG_MAX + 1);
  localparam int IDX_W  = $clog2(MSG_MAX);
  localparam int CMD_W  = 1 + 8 + FILL_W;

  logic             fifo_push;
  logic [CMD_W-1:0] fifo_din;
  logic             fifo_full;
  logic             fifo_pop;
  logic [CMD_W-1:0] fifo_dout;
  logic             fifo_empty;
  logic             mem_we;
  logic [IDX_W:0]   mem_waddr;
  byte_t            mem_wdata;
  logic             rel_v;
  logic             rel_bank;

  // parser front
  mma_front #(
    .MSG_MAX (MSG_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .cmd_push  (fifo_push),
    .cmd_data  (fifo_din),
    .cmd_full  (fifo_full),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .rel_v     (rel_v),
    .rel_bank  (rel_bank)
  );

  // command queue
  mma_cmd_fifo #(
    .W (CMD_W)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fifo_push),
    .din   (fifo_din),
    .full  (fifo_full),
    .pop   (fifo_pop),
    .dout  (fifo_dout),
    .empty (fifo_empty)
  );

  // emitter back
  mma_back #(
    .MSG_MAX (MSG_MAX)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (fifo_empty),
    .cmd_pop   (fifo_pop),
    .cmd_data  (fifo_dout),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .rel_v     (rel_v),
    .rel_bank  (rel_bank),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last_of_message)
  );

  // front never queues a command into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> !fifo_full)
    else $error("command pushed into full queue");

  // the bank being released is never the bank being written
  a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && rel_v) |-> (mem_waddr[IDX_W] != rel_bank))
    else $error("store write hit a bank still owned by the emitter");

  // a bank is released once per message, never on back-to-back cycles
  a_rel_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    rel_v |=> !rel_v)
    else $error("bank release repeated");

endmodule

// File: tb/tb.sv
// tb: self-checking testbench for midi_message_assembler; drives raw midi bytes,
// predicts the assembled beats and checks them in order
// depends on sv/mma_pkg.sv and sv/midi_message_assembler.sv
`timescale 1ns / 1ps

module tb
  import mma_pkg::*;
();

  localparam int MSG_MAX    = 16;
  localparam int CYCLE_CAP  = 200000;
  localparam int TAIL_WAIT  = 64;
  localparam int LONG_HOLD  = 400;
  localparam int RAND_BYTES = 20;

  // channel voice status codes (channel nibble zero)
  localparam byte_t NOTE_ON    = 8'h90;
  localparam byte_t CTRL_CHG   = 8'hB0;
  localparam byte_t PROG_CHG   = 8'hC0;
  localparam byte_t PITCH_BEND = 8'hE0;
  // system common and real-time codes
  localparam byte_t MTC_QFRAME = 8'hF1;
  localparam byte_t SONG_POS   = 8'hF2;
  localparam byte_t SONG_SEL   = 8'hF3;
  localparam byte_t UNDEF_F4   = 8'hF4;
  localparam byte_t UNDEF_F5   = 8'hF5;
  localparam byte_t TUNE_REQ   = 8'hF6;
  localparam byte_t TIMING_CLK = 8'hF8;
  localparam byte_t SYS_RESET  = 8'hFF;
  localparam byte_t DATA_MAX   = 8'h7F;

  // full message lengths, status byte included
  localparam msg_len_t CHAN_MSG_LEN [7] = '{2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3};
  localparam msg_len_t SYS_MSG_LEN [8]  = '{2'd0, 2'd2, 2'd3, 2'd2, 2'd0, 2'd0, 2'd1, 2'd1};

  typedef struct packed {
    byte_t data;
    logic  last;
  } beat_t;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  byte_t in_byte;
  logic  out_valid;
  logic  out_ready;
  byte_t out_byte;
  logic  out_last_of_message;

  // predictor state
  byte_t    run_status = '0;
  msg_len_t msg_len    = '0;
  int       fill_cnt   = 0;
  byte_t    msg_buf [MSG_MAX];
  beat_t    expected_beats [$];

  int errors      = 0;
  int beats_seen  = 0;
  int bytes_sent  = 0;
  int cycle_count = 0;
  bit tx_idle     = 1'b1;
  bit rx_idle     = 1'b1;
  int hold_pending = 0;

  midi_message_assembler #(
    .MSG_MAX(MSG_MAX)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_byte             (in_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_last_of_message (out_last_of_message)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("%0t: timeout, %0d beats still expected", $time, expected_beats.size());
      $display("midi_message_assembler test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function void push_beat(input byte_t b, input logic last);
    beat_t e;
    e.data = b;
    e.last = last;
    expected_beats.push_back(e);
  endfunction

  function void store_byte(input byte_t b);
    if (fill_cnt < MSG_MAX) begin
      msg_buf[fill_cnt] = b;
      fill_cnt++;
    end
  endfunction

  function void flush_store();
    for (int k = 0; k < fill_cnt; k++) begin
      push_beat(msg_buf[k], k + 1 == fill_cnt);
    end
  endfunction

  // advance the predictor by one accepted raw byte
  function void assemble_byte(input byte_t c);
    if (c >= RT_FIRST) begin
      // real-time passes straight through, active sensing vanishes
      if (c != ACTIVE_SENSE) push_beat(c, 1'b1);
    end else if (c == SX_END) begin
      if (run_status == SX_START) begin
        store_byte(c);
        flush_store();
      end
      run_status = '0;
      fill_cnt   = 0;
    end else if (c >= STATUS_FIRST) begin
      // new status drops whatever was half built
      if (c >= SYS_FIRST) msg_len = SYS_MSG_LEN[c[2:0]];
      else msg_len = CHAN_MSG_LEN[c[6:4]];
      msg_buf[0] = c;
      run_status = c;
      fill_cnt   = 1;
      if (msg_len == 2'd1) begin
        flush_store();
        run_status = '0;
        fill_cnt   = 0;
      end
    end else if (run_status != '0) begin
      // running status goes back in front of a fresh message
      if (fill_cnt == 0 && run_status != SX_START) store_byte(run_status);
      store_byte(c);
      if (fill_cnt == msg_len) begin
        flush_store();
        if (run_status >= SYS_FIRST) run_status = '0;
        fill_cnt = 0;
      end else if (fill_cnt >= MSG_MAX) begin
        flush_store();
        fill_cnt = 0;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result side: ready pattern and checker
  // ---------------------------------------------------------------------------

  // receiver: random wait after each beat while rx_idle is set, plus long hold-offs on request
  initial begin
    int rx_wait;
    int hold_left;
    int w;
    rx_wait   = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending > 0) begin
        hold_left    = hold_pending;
        hold_pending = 0;
      end
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (out_ready && out_valid) begin
        w = rx_idle ? $urandom_range(0, 10) : 0;
        rx_wait = w;
        out_ready <= (w == 0);
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= (rx_wait == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each accepted beat with the oldest expectation
  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors < 32)
          $display("%0t: unexpected beat, expected none, got byte %02h last %0b",
                   $time, out_byte, out_last_of_message);
      end else begin
        e = expected_beats.pop_front();
        if (out_byte !== e.data || out_last_of_message !== e.last) begin
          errors++;
          if (errors < 32)
            $display("%0t: beat %0d mismatch, expected byte %02h last %0b, got byte %02h last %0b",
                     $time, beats_seen, e.data, e.last, out_byte, out_last_of_message);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side helpers
  // ---------------------------------------------------------------------------

  // offer one byte, hold it until accepted, then update the predictor
  task automatic send_byte(input byte_t b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    assemble_byte(b);
    bytes_sent++;
  endtask

  // stop offering and wait until every expected beat has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
  endtask

  function automatic byte_t rand_data();
    return byte_t'($urandom_range(0, DATA_MAX));
  endfunction

  // data byte, now and then preceded by a real-time byte
  task automatic send_data(input byte_t b);
    if ($urandom_range(0, 11) == 0) send_byte(byte_t'($urandom_range(RT_FIRST, SYS_RESET)));
    send_byte(b);
  endtask

  // voice status and its data, repeated under running status
  task automatic send_voice_run(input int repeats);
    byte_t st;
    int    sel;
    sel = $urandom_range(0, 6);
    st  = {1'b1, 3'(sel), 4'($urandom_range(0, 15))};
    send_byte(st);
    for (int r = 0; r < repeats; r++) begin
      for (int k = 1; k < CHAN_MSG_LEN[sel]; k++) send_data(rand_data());
    end
  endtask

  // open-ended message: opener, payload, closing byte
  task automatic send_bulk(input byte_t opener, input int n);
    send_byte(opener);
    for (int k = 0; k < n; k++) send_data(rand_data());
    send_byte(SX_END);
  endtask

  function automatic int bulk_size();
    case ($urandom_range(0, 7))
      0:       return MSG_MAX - 1;
      1:       return MSG_MAX;
      2:       return $urandom_range(2 * MSG_MAX - 2, 2 * MSG_MAX + 1);
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // no status yet: data and a stray sysex end are dropped
  task automatic test_orphan_data();
    send_byte(8'h00);
    send_byte(DATA_MAX);
    send_byte(SX_END);
  endtask

  task automatic test_realtime();
    send_byte(TIMING_CLK);
    send_byte(ACTIVE_SENSE);
    send_byte(SYS_RESET);
  endtask

  // complete voice message, running status repeat, two-byte message
  task automatic test_voice();
    send_byte(NOTE_ON);
    send_byte(8'h00);
    send_byte(DATA_MAX);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(PROG_CHG);
    send_byte(DATA_MAX);
  endtask

  // real-time inside a message, then a new status cuts the message short
  task automatic test_interrupted();
    send_byte(CTRL_CHG);
    send_byte(TIMING_CLK);
    send_byte(8'h07);
    send_byte(PITCH_BEND);
    send_byte(DATA_MAX);
    send_byte(DATA_MAX);
  endtask

  // common messages clear running status; tune request goes out at once
  task automatic test_common();
    send_byte(MTC_QFRAME);
    send_byte(8'h55);
    send_byte(TUNE_REQ);
    send_byte(SONG_POS);
    send_byte(DATA_MAX);
    send_byte(8'h2A);
    send_byte(8'h11);
  endtask

  task automatic test_short_sysex();
    send_bulk(SX_START, 1);
    drain();
  endtask

  // receiver stops for a long stretch while input keeps coming at full rate
  task automatic test_backpressure();
    tx_idle = 1'b0;
    hold_pending = LONG_HOLD;
    send_bulk(SX_START, MSG_MAX + 4);
    for (int k = 0; k < 4; k++) send_voice_run(2);
    send_bulk(UNDEF_F5, MSG_MAX + 2);
    tx_idle = 1'b1;
    drain();
  endtask

  // mostly well-formed traffic with random content, some noise and cut messages
  task automatic test_random();
    int start;
    int kind;
    start = bytes_sent;
    while (bytes_sent - start < RAND_BYTES) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 11);
      case (kind)
        0, 1, 2: send_voice_run($urandom_range(1, 3));
        3: begin
          case ($urandom_range(0, 3))
            0: begin send_byte(MTC_QFRAME); send_data(rand_data()); end
            1: begin send_byte(SONG_POS); send_data(rand_data()); send_data(rand_data()); end
            2: begin send_byte(SONG_SEL); send_data(rand_data()); end
            default: send_byte(TUNE_REQ);
          endcase
        end
        4, 5: send_bulk(SX_START, bulk_size());
        6: send_bulk($urandom_range(0, 1) ? UNDEF_F4 : UNDEF_F5, bulk_size());
        7: begin
          // message cut short by the next status
          send_byte({1'b1, 3'($urandom_range(0, 6)), 4'($urandom_range(0, 15))});
          if ($urandom_range(0, 1)) send_data(rand_data());
        end
        8: begin
          // open sysex, left open for the next traffic to cut short or close
          send_byte(SX_START);
          repeat ($urandom_range(1, 5)) send_data(rand_data());
        end
        9: send_byte(byte_t'($urandom_range(RT_FIRST, SYS_RESET)));
        default: repeat ($urandom_range(1, 4)) send_byte(byte_t'($urandom_range(0, 255)));
      endcase
      if ($urandom_range(0, 15) == 0) drain();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_valid <= 1'b0;
    in_byte  <= '0;
    rst_n    <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_orphan_data();
    test_realtime();
    test_voice();
    test_interrupted();
    test_common();
    test_short_sysex();
    test_backpressure();
    test_random();

    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("midi_message_assembler test passed");
    end else begin
      $display("midi_message_assembler test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/mma_pkg.sv
sv/mma_cmd_fifo.sv
sv/mma_front.sv
sv/mma_back.sv
sv/midi_message_assembler.sv
tb/tb.sv
